// ===== rtl/cdq_pkg.sv =====
// Shared types and codes for the circular deque core.
`default_nettype none

package cdq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OCC_W  = 5;

   // Request operation codes
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_LIST       = 3'd4;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] item;
      logic [OCC_W-1:0]         occupancy;
      logic                     final_res;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_LIST_START,
      OP_LIST_STEP
   } op_type;

   // Controller to datapath
   typedef struct packed {
      op_type     op;
      logic       load_out;
      logic [1:0] out_status;
      logic       out_from_mem;
      logic       out_final;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/cdq_dpath.sv =====
// Datapath: ring storage, front/fill pointers, listing walker and response register.
`default_nettype none

module cdq_dpath #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cdq_pkg::cmd_type                  cmd,
   input  wire logic signed [cdq_pkg::DATA_W-1:0] value,
   input  wire logic                              rsp_stall,
   output cdq_pkg::stat_type                      stat,
   output logic                                   rsp_valid,
   output cdq_pkg::rsp_type                       rsp_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned FW = $clog2(DEPTH + 1);
   localparam int unsigned SW = FW + 1;

   logic signed [cdq_pkg::DATA_W-1:0] mem [DEPTH];

   logic [AW-1:0] front_ff, front_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] lptr_ff, lptr_in;
   logic [FW-1:0] lcnt_ff, lcnt_in;
   logic signed [cdq_pkg::DATA_W-1:0] rd_ff;
   cdq_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [AW-1:0] back_idx, tail_idx;
   logic [SW-1:0] end_sum;
   logic [cdq_pkg::OCC_W+FW-1:0] occ_ext;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
      return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
   endfunction

   // sum stays below twice DEPTH, so one compare and subtract folds it
   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      return (s >= SW'(DEPTH)) ? AW'(s - SW'(DEPTH)) : AW'(s);
   endfunction

   assign end_sum  = SW'(front_ff) + SW'(fill_ff);
   assign back_idx = wrap(end_sum);
   // only used when fill is nonzero
   assign tail_idx = wrap(end_sum - SW'(1));

   always_comb begin
      front_in = front_ff;
      fill_in  = fill_ff;
      lptr_in  = lptr_ff;
      lcnt_in  = lcnt_ff;
      wr_en    = 1'b0;
      wr_addr  = back_idx;
      rd_en    = 1'b0;
      rd_addr  = front_ff;
      unique case (cmd.op)
         cdq_pkg::OP_PUSH_FRONT: begin
            front_in = prev_idx(front_ff);
            wr_en    = 1'b1;
            wr_addr  = prev_idx(front_ff);
            fill_in  = fill_ff + FW'(1);
         end
         cdq_pkg::OP_PUSH_BACK: begin
            wr_en   = 1'b1;
            wr_addr = back_idx;
            fill_in = fill_ff + FW'(1);
         end
         cdq_pkg::OP_POP_FRONT: begin
            rd_en    = 1'b1;
            rd_addr  = front_ff;
            front_in = next_idx(front_ff);
            fill_in  = fill_ff - FW'(1);
         end
         cdq_pkg::OP_POP_BACK: begin
            rd_en   = 1'b1;
            rd_addr = tail_idx;
            fill_in = fill_ff - FW'(1);
         end
         cdq_pkg::OP_LIST_START: begin
            rd_en   = 1'b1;
            rd_addr = front_ff;
            lptr_in = next_idx(front_ff);
            lcnt_in = FW'(1);
         end
         cdq_pkg::OP_LIST_STEP: begin
            rd_en   = 1'b1;
            rd_addr = lptr_ff;
            lptr_in = next_idx(lptr_ff);
            lcnt_in = lcnt_ff + FW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // occupancy reported after the operation, low bits only
   assign occ_ext = {{cdq_pkg::OCC_W{1'b0}}, fill_in};

   always_comb begin
      rsp_in.status    = cmd.out_status;
      rsp_in.item      = cmd.out_from_mem ? rd_ff : '0;
      rsp_in.occupancy = occ_ext[cdq_pkg::OCC_W-1:0];
      rsp_in.final_res = cmd.out_final;
      rsp_valid_in     = cmd.load_out | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         fill_ff      <= '0;
         lptr_ff      <= '0;
         lcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         lptr_ff      <= lptr_in;
         lcnt_ff      <= lcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.empty     = (fill_ff == '0);
   assign stat.full      = (fill_ff == FW'(DEPTH));
   assign stat.list_last = (lcnt_ff == fill_ff);
   assign stat.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// Controller: request decode and sequencing of pops and listings.
`default_nettype none

module cdq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [2:0]        req_mode,
   input  wire cdq_pkg::stat_type stat,
   output logic                   req_stall,
   output cdq_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_LIST
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) | ~stat.out_free;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in         = state_ff;
      cmd.op           = cdq_pkg::OP_NONE;
      cmd.load_out     = 1'b0;
      cmd.out_status   = cdq_pkg::STATUS_OK;
      cmd.out_from_mem = 1'b0;
      cmd.out_final    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_BACK: begin
                     cmd.load_out = 1'b1;
                     if (stat.full) begin
                        cmd.out_status = cdq_pkg::STATUS_FULL;
                     end else begin
                        cmd.op = (req_mode == cdq_pkg::MODE_PUSH_FRONT) ?
                                 cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
                     end
                  end
                  cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.op   = (req_mode == cdq_pkg::MODE_POP_FRONT) ?
                                   cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
                        state_in = ST_POP;
                     end
                  end
                  cdq_pkg::MODE_LIST: begin
                     if (stat.empty) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.op   = cdq_pkg::OP_LIST_START;
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     cmd.load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            // read data lands in the cycle after the pop is issued
            if (stat.out_free) begin
               cmd.load_out     = 1'b1;
               cmd.out_from_mem = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_LIST: begin
            // hand off the fetched element and fetch the next one together
            if (stat.out_free) begin
               cmd.load_out     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_final    = stat.list_last;
               if (stat.list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.op = cdq_pkg::OP_LIST_STEP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
// Top level of the circular deque: bounded double-ended queue on a ring buffer.
//
//   Channel   Dir   Ports                               Payload
//   request   in    req_valid, req_stall, req_data      mode, value
//   response  out   rsp_valid, rsp_stall, rsp_data      status, item, occupancy, final_res
//
// Push, refused push, empty pop and other single-response requests: answered at accept.
// Pop: the storage read is registered first, then the response is loaded from it.
// Listing of N elements: one element per cycle from the storage read port unless stalled.
// Reset clears pointers, fill count and response valid; storage contents are left as is.
// A stalled response holds; a new request is taken only once the response register
// can accept its first result.
`default_nettype none

module circular_deque_core #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cdq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cdq_pkg::rsp_type       rsp_data
);

   cdq_pkg::cmd_type  cmd;
   cdq_pkg::stat_type stat;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     (req_data.value),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cdq_pkg::OP_POP_FRONT || cmd.op == cdq_pkg::OP_POP_BACK) |-> !stat.empty)
      else $error("pop issued on empty deque");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cdq_pkg::OP_PUSH_FRONT || cmd.op == cdq_pkg::OP_PUSH_BACK) |-> !stat.full)
      else $error("push issued on full deque");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("response overwritten while stalled");

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != cdq_pkg::STATUS_OK) |-> rsp_data.final_res)
      else $error("error response not marked final");

endmodule

`default_nettype wire
